// ===== rtl/core/wtr_pkg.sv =====
// Package for the word to radix text encoder.
// Holds field widths, the radix reset value and the operation codes.
// No dependencies.
package wtr_pkg;

  localparam int RADIX_W   = 7;
  localparam int IDX_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int VAL_W     = 6;
  localparam int VB_W      = 3;
  localparam int BYTE_BITS = 8;
  localparam int DIV_STEP  = 8;
  localparam int RADIX_MAX = (1 << RADIX_W) - 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

endpackage

// ===== rtl/core/word_to_radix_text_encoder.sv =====
// Word to radix text encoder, top level.
// Holds the alphabet and digit memories, the radix divider and the emit pipeline.
// Depends on wtr_pkg.
//
// Usage: write the radix through cfg_we_i / cfg_wdata_i while the block is idle.
// Input transactions (in_valid_i, in_stall_o) either load one alphabet entry or
// encode one data word; output transactions (out_valid_o, out_stall_i) carry one
// digit each, most significant first, with leading zeros of the message dropped.
// A load transaction writes one alphabet entry. In an encode transaction the remainder
// divider retires 8 quotient bits per cycle, dividing the masked data word and an
// all-ones mask word side by side, and stores one digit per pass until the mask
// quotient is zero; then the emit pipeline reads the digit memory and the alphabet
// memory and delivers one digit per cycle while the output is not stalled.
// in_stall_o is high from the accepted encode transaction until the block returns
// to idle once its emit pipeline has emptied after the last digit; a digit
// waiting in the output register does not block the next transaction. A stalled
// output holds its register and freezes the emit pipeline. Reset sets the radix
// to 16, clears the message state and empties both channels; the alphabet is
// undefined until loaded.
module word_to_radix_text_encoder #(
  parameter int WORD_BITS     = 32,
  parameter int ALPHABET_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wtr_pkg::RADIX_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [wtr_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [wtr_pkg::CHAR_W-1:0]   entry_char_i,
  input  logic [WORD_BITS-1:0]         data_word_i,
  input  logic [wtr_pkg::VB_W-1:0]     valid_bytes_i,
  input  logic                         final_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wtr_pkg::CHAR_W-1:0]   digit_char_o,
  output logic [wtr_pkg::VAL_W-1:0]    digit_value_o,
  output logic                         last_of_item_o,
  output logic                         end_of_text_o
);

  localparam int RW    = wtr_pkg::RADIX_W;
  localparam int STEP  = wtr_pkg::DIV_STEP;
  localparam int RMAX  = (ALPHABET_SIZE < wtr_pkg::RADIX_MAX) ? ALPHABET_SIZE
                                                              : wtr_pkg::RADIX_MAX;
  localparam int DW    = $clog2(RMAX);
  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam int BW    = $clog2(WORD_BITS);
  localparam int ITERS = (WORD_BITS + STEP - 1) / STEP;
  localparam int WP    = ITERS * STEP;
  localparam int IW    = (ITERS > 1) ? $clog2(ITERS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [RW-1:0]               radix_q;
  logic                        seen_q;
  logic                        fin_q;
  logic [WP-1:0]               quo_q, mq_q, quo_d, mq_d;
  logic [RW-1:0]               rem_q, mrem_q, rem_d, mrem_d;
  logic [STEP-1:0]             qb, mqb;
  logic [RW:0]                 t, mt;
  logic [IW-1:0]               iter_q;
  logic [BW-1:0]               dig_cnt_q;
  logic [BW-1:0]               k_q;
  logic                        a_v_q, b_v_q, c_v_q;
  logic                        b_last_q, c_last_q;
  logic [DW-1:0]               c_val_q;
  logic                        out_v_q;
  logic [wtr_pkg::CHAR_W-1:0]  out_char_q;
  logic [wtr_pkg::VAL_W-1:0]   out_val_q;
  logic                        out_last_q, out_eot_q;

  logic [RW-1:0]               r_eff;
  logic [WORD_BITS-1:0]        word_m;
  logic                        in_accept;
  logic                        advance;
  logic                        div_last;
  logic [DW-1:0]               dig_b;
  logic                        emit_b;
  logic                        tab_we, tab_re, dbuf_we, dbuf_re;

  logic [wtr_pkg::CHAR_W-1:0]  tab_mem [ALPHABET_SIZE];
  logic [wtr_pkg::CHAR_W-1:0]  tab_rd_q;
  logic [DW-1:0]               dbuf_mem [WORD_BITS];
  logic [DW-1:0]               dbuf_rd_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign advance    = !out_v_q || !out_stall_i;
  assign div_last   = (iter_q == IW'(ITERS - 1));

  assign out_valid_o    = out_v_q;
  assign digit_char_o   = out_char_q;
  assign digit_value_o  = out_val_q;
  assign last_of_item_o = out_last_q;
  assign end_of_text_o  = out_eot_q;

  always_comb begin
    if (radix_q < wtr_pkg::RADIX_MIN) begin
      r_eff = wtr_pkg::RADIX_MIN;
    end else if (int'(radix_q) > ALPHABET_SIZE) begin
      r_eff = RW'(RMAX);
    end else begin
      r_eff = radix_q;
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      word_m[b] = data_word_i[b] && ((b / wtr_pkg::BYTE_BITS) < int'(valid_bytes_i));
    end
  end

  always_comb begin
    rem_d  = rem_q;
    mrem_d = mrem_q;
    qb     = '0;
    mqb    = '0;
    t      = '0;
    mt     = '0;
    for (int i = 0; i < STEP; i++) begin
      t = {rem_d, quo_q[WP-1-i]};
      if (t >= {1'b0, r_eff}) begin
        t = t - {1'b0, r_eff};
        qb[STEP-1-i] = 1'b1;
      end
      rem_d = t[RW-1:0];
      mt = {mrem_d, mq_q[WP-1-i]};
      if (mt >= {1'b0, r_eff}) begin
        mt = mt - {1'b0, r_eff};
        mqb[STEP-1-i] = 1'b1;
      end
      mrem_d = mt[RW-1:0];
    end
    quo_d = (quo_q << STEP) | WP'(qb);
    mq_d  = (mq_q << STEP) | WP'(mqb);
  end

  assign dig_b  = dbuf_rd_q;
  assign emit_b = seen_q || (dig_b != '0) || (b_last_q && fin_q);

  assign tab_we  = in_accept && (wtr_pkg::op_e'(operation_i) == wtr_pkg::OP_LOAD)
                   && (int'(entry_index_i) < ALPHABET_SIZE);
  assign tab_re  = (state_q == S_EMIT) && advance && b_v_q && emit_b;
  assign dbuf_we = (state_q == S_DIV) && div_last;
  assign dbuf_re = (state_q == S_EMIT) && advance && a_v_q;

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[AW'(entry_index_i)] <= entry_char_i;
    end
    if (tab_re) begin
      tab_rd_q <= tab_mem[AW'(dig_b)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dbuf_we) begin
      dbuf_mem[dig_cnt_q] <= rem_d[DW-1:0];
    end
    if (dbuf_re) begin
      dbuf_rd_q <= dbuf_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      radix_q    <= wtr_pkg::RADIX_RESET;
      seen_q     <= 1'b0;
      fin_q      <= 1'b0;
      quo_q      <= '0;
      mq_q       <= '0;
      rem_q      <= '0;
      mrem_q     <= '0;
      iter_q     <= '0;
      dig_cnt_q  <= '0;
      k_q        <= '0;
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      c_v_q      <= 1'b0;
      b_last_q   <= 1'b0;
      c_last_q   <= 1'b0;
      c_val_q    <= '0;
      out_v_q    <= 1'b0;
      out_char_q <= '0;
      out_val_q  <= '0;
      out_last_q <= 1'b0;
      out_eot_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (advance) begin
        out_v_q <= c_v_q;
        if (c_v_q) begin
          out_char_q <= tab_rd_q;
          out_val_q  <= wtr_pkg::VAL_W'(c_val_q);
          out_last_q <= c_last_q;
          out_eot_q  <= c_last_q && fin_q;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept && (wtr_pkg::op_e'(operation_i) == wtr_pkg::OP_ENCODE)) begin
            quo_q     <= WP'(word_m);
            mq_q      <= WP'({WORD_BITS{1'b1}});
            rem_q     <= '0;
            mrem_q    <= '0;
            iter_q    <= '0;
            dig_cnt_q <= '0;
            fin_q     <= final_word_i;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          quo_q <= quo_d;
          mq_q  <= mq_d;
          if (div_last) begin
            iter_q <= '0;
            rem_q  <= '0;
            mrem_q <= '0;
            if (mq_d == '0) begin
              k_q     <= dig_cnt_q;
              a_v_q   <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              dig_cnt_q <= dig_cnt_q + 1'b1;
            end
          end else begin
            rem_q  <= rem_d;
            mrem_q <= mrem_d;
            iter_q <= iter_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (advance) begin
            if (a_v_q) begin
              b_v_q    <= 1'b1;
              b_last_q <= (k_q == '0);
              if (k_q == '0) begin
                a_v_q <= 1'b0;
              end else begin
                k_q <= k_q - 1'b1;
              end
            end else begin
              b_v_q <= 1'b0;
            end
            c_v_q <= b_v_q && emit_b;
            if (b_v_q && emit_b) begin
              c_val_q  <= dig_b;
              c_last_q <= b_last_q;
            end
            if (b_v_q) begin
              if (b_last_q && fin_q) begin
                seen_q <= 1'b0;
              end else if (emit_b) begin
                seen_q <= 1'b1;
              end
            end
          end
          if (!a_v_q && !b_v_q && !c_v_q) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
